// ===== src/u8u2_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 16;
   localparam int COUNT_W = 2;

   localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 16'h003F;

   // Register index, taken from the word-aligned address bit
   typedef enum logic [0:0] {
      CSR_REPLACEMENT_CODE = 1'b0,
      CSR_UNMAPPED         = 1'b1
   } csr_index_type;

   // Continuation bytes still expected after a lead byte
   localparam logic [COUNT_W-1:0] REMAIN_NONE  = 2'd0;
   localparam logic [COUNT_W-1:0] REMAIN_TWO   = 2'd1;
   localparam logic [COUNT_W-1:0] REMAIN_THREE = 2'd2;
   localparam logic [COUNT_W-1:0] REMAIN_FOUR  = 2'd3;

   localparam logic [2:0] LEAD_TWO_TAG   = 3'b110;
   localparam logic [3:0] LEAD_THREE_TAG = 4'b1110;

endpackage

// ===== src/utf8_to_ucs2_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core
// Decodes a UTF-8 byte stream, one byte per item, into 16-bit code units.
// ----------------------------------------------------------------------------
// A character's last byte reaches rsp via the input and result registers.
// Throughput: 1 byte per cycle unless rsp_ready holds the result register;
// a held result register also holds the input register and decode state.
// Reset: synchronous; clears decode state and valids, and sets the
// replacement code to '?'.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [u8u2_pkg::BYTE_W-1:0]      req_data_byte,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [u8u2_pkg::CODE_W-1:0]      rsp_code_unit,
   output logic                             rsp_end_of_string,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [u8u2_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [u8u2_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [u8u2_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import u8u2_pkg::*;

   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;

   logic [COUNT_W-1:0]    remain_ff, remain_in;
   logic [CODE_W-1:0]     partial_ff, partial_in;
   logic                  replace_ff, replace_in;
   logic [CODE_W-1:0]     replacement_ff;

   logic                  out_valid_ff;
   logic [CODE_W-1:0]     out_code_ff;
   logic                  out_eos_ff;

   logic                  advance;
   logic                  emit;
   logic [CODE_W-1:0]     emit_code;
   logic                  emit_eos;
   logic [COUNT_W-1:0]    remain_dec;
   csr_index_type         csr_index;
   logic                  csr_write;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         CSR_REPLACEMENT_CODE: begin
            csr_prdata = {{(CSR_DATA_W-CODE_W){1'b0}}, replacement_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replacement_ff <= REPLACEMENT_RESET;
      end else if (csr_write && csr_index == CSR_REPLACEMENT_CODE) begin
         replacement_ff <= csr_pwdata[CODE_W-1:0];
      end
   end

   // Handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Decode step
   assign remain_dec = remain_ff - 2'd1;

   always_comb begin
      remain_in  = remain_ff;
      partial_in = partial_ff;
      replace_in = replace_ff;
      emit       = 1'b0;
      emit_code  = '0;
      emit_eos   = 1'b0;
      if (remain_ff == REMAIN_NONE) begin
         if (in_byte_ff == '0) begin
            emit     = 1'b1;
            emit_eos = 1'b1;
         end else if (!in_byte_ff[7]) begin
            emit      = 1'b1;
            emit_code = {{(CODE_W-BYTE_W){1'b0}}, in_byte_ff};
         end else if (in_byte_ff[7:5] == LEAD_TWO_TAG) begin
            partial_in = {5'b0, in_byte_ff[4:0], 6'b0};
            remain_in  = REMAIN_TWO;
            replace_in = 1'b0;
         end else if (in_byte_ff[7:4] == LEAD_THREE_TAG) begin
            partial_in = {in_byte_ff[3:0], 12'b0};
            remain_in  = REMAIN_THREE;
            replace_in = 1'b0;
         end else begin
            partial_in = '0;
            remain_in  = REMAIN_FOUR;
            replace_in = 1'b1;
         end
      end else begin
         remain_in = remain_dec;
         if (replace_ff) begin
            if (remain_dec == REMAIN_NONE) begin
               replace_in = 1'b0;
               emit       = 1'b1;
               emit_code  = replacement_ff;
            end
         end else if (remain_dec != REMAIN_NONE) begin
            partial_in = partial_ff | {4'b0, in_byte_ff[5:0], 6'b0};
         end else begin
            emit       = 1'b1;
            emit_code  = partial_ff | {10'b0, in_byte_ff[5:0]};
            partial_in = '0;
         end
      end
   end

   // Input register and decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         remain_ff   <= REMAIN_NONE;
         partial_ff  <= '0;
         replace_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            remain_ff  <= remain_in;
            partial_ff <= partial_in;
            replace_ff <= replace_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_code_ff <= emit_code;
         out_eos_ff  <= emit_eos;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_code_unit     = out_code_ff;
   assign rsp_end_of_string = out_eos_ff;

endmodule
